// ===== src/sct_pkg.sv =====
package sct_pkg;

  localparam int HISTORY_DEPTH_DEF = 3;

  localparam int DIV_W     = 20;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int DVSR_W    = 32;
  localparam int SUM_W     = 18;

  localparam logic [DIV_W-1:0] CAD_NUM      = 20'd960000;
  localparam logic [13:0]      CAD_MAX_Q4   = 14'd9600;
  localparam logic [11:0]      BEAT_MAX_MS  = 12'd4095;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAG_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTVL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BEAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BEAT   = 3'd4;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               pos_valid;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic        step;
    logic [13:0] avg_cadence_q4;
    logic [1:0]  cadence_count;
    logic [11:0] beat_interval_ms;
  } out_item_t;

  typedef struct packed {
    logic [11:0] magnitude_threshold;
    logic [15:0] refractory_ms;
    logic [15:0] min_interval_ms;
    logic [9:0]  min_beat_cadence;
    logic [9:0]  max_beat_cadence;
  } cfg_t;

  typedef struct packed {
    logic        step;
    logic        cad_needed;
    logic [31:0] dt;
  } step_ev_t;

endpackage

// ===== src/sct_div.sv =====
module sct_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sct_pkg::DIV_W-1:0]      dividend,
  input  logic [sct_pkg::DVSR_W-1:0]     divisor,
  output logic                           done,
  output logic [sct_pkg::DIV_W-1:0]      quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [sct_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [sct_pkg::DIV_W-1:0]         rem_r;
  logic [sct_pkg::DIV_W-1:0]         quo_r;
  logic [sct_pkg::DVSR_W-1:0]        dvs_r;
  logic [sct_pkg::DIV_W:0]           shifted;
  logic [sct_pkg::DVSR_W-1:0]        shifted_ext;
  logic [sct_pkg::DVSR_W-1:0]        diff;
  logic                              ge;

  assign shifted     = {rem_r, quo_r[sct_pkg::DIV_W-1]};
  assign shifted_ext = sct_pkg::DVSR_W'(shifted);
  assign ge          = shifted_ext >= dvs_r;
  assign diff        = shifted_ext - dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= sct_pkg::DIV_CNT_W'(sct_pkg::DIV_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[sct_pkg::DIV_W-2:0], ge};
      rem_r <= ge ? diff[sct_pkg::DIV_W-1:0] : shifted[sct_pkg::DIV_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("Divider started while an item is still being divided.");
`endif

endmodule

// ===== src/sct_queue.sv =====
module sct_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sct_pkg::step_ev_t wdata,
  output logic              full,
  input  logic              pop,
  output sct_pkg::step_ev_t rdata,
  output logic              empty
);

  sct_pkg::step_ev_t mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("Event queue count exceeds its depth.");
`endif

endmodule

// ===== src/sct_front.sv =====
module sct_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sct_pkg::cfg_t     cfg,
  input  logic              in_push,
  input  sct_pkg::in_item_t in_data,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_push,
  output sct_pkg::step_ev_t q_data
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;
  localparam logic [1:0] F_DEC  = 2'd3;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic signed [15:0] prev_x_r;
  logic signed [15:0] prev_y_r;
  logic               primed_r;
  logic [32:0]        motion_r;
  logic [31:0]        last_r;
  logic [31:0]        now_r;
  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;
  logic               upd_r;
  logic [32:0]        sqx_r;
  logic [32:0]        sqy_r;
  logic [23:0]        thr_sq_r;
  logic [31:0]        dt_r;
  logic signed [33:0] px;
  logic signed [33:0] py;
  logic [23:0]        thr_sq;
  logic               step;
  logic               accept;

  assign accept = state_r == F_IDLE && in_push;
  assign px     = dx_r * dx_r;
  assign py     = dy_r * dy_r;
  assign thr_sq = cfg.magnitude_threshold * cfg.magnitude_threshold;

  assign step = (motion_r > {9'd0, thr_sq_r}) && (dt_r > {16'd0, cfg.refractory_ms});

  assign q_push          = state_r == F_DEC && !q_full;
  assign q_data.step       = step;
  assign q_data.cad_needed = step && last_r != 32'd0 && dt_r > {16'd0, cfg.min_interval_ms};
  assign q_data.dt         = dt_r;
  assign in_full           = state_r != F_IDLE;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_SUM;
      end
      F_SUM: begin
        state_nxt = F_DEC;
      end
      F_DEC: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      prev_x_r <= '0;
      prev_y_r <= '0;
      primed_r <= 1'b0;
      motion_r <= '0;
      last_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_data.pos_valid) begin
        primed_r <= 1'b1;
        prev_x_r <= in_data.pos_x;
        prev_y_r <= in_data.pos_y;
      end
      if (state_r == F_SUM && upd_r) begin
        motion_r <= sqx_r + sqy_r;
      end
      if (q_push && step) begin
        last_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r  <= {in_data.pos_x[15], in_data.pos_x} - {prev_x_r[15], prev_x_r};
      dy_r  <= {in_data.pos_y[15], in_data.pos_y} - {prev_y_r[15], prev_y_r};
      upd_r <= in_data.pos_valid && primed_r;
      now_r <= in_data.now_ms;
    end
    if (state_r == F_MUL) begin
      sqx_r    <= px[32:0];
      sqy_r    <= py[32:0];
      thr_sq_r <= thr_sq;
    end
    if (state_r == F_SUM) begin
      dt_r <= now_r - last_r;
    end
  end

endmodule

// ===== src/sct_back.sv =====
module sct_back #(
  parameter int HISTORY_DEPTH = sct_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sct_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  sct_pkg::step_ev_t  q_data,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output sct_pkg::out_item_t out_data
);

  localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_CAD   = 3'd1;
  localparam logic [2:0] B_AVGS  = 3'd2;
  localparam logic [2:0] B_AVG   = 3'd3;
  localparam logic [2:0] B_BEAT  = 3'd4;
  localparam logic [2:0] B_BWAIT = 3'd5;
  localparam logic [2:0] B_OUT   = 3'd6;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [13:0]                   ring_r [HISTORY_DEPTH];
  logic [HEAD_W-1:0]             head_r;
  logic [FILL_W-1:0]             fill_r;
  logic [sct_pkg::SUM_W-1:0]     sum_r;
  logic [13:0]                   avg_r;
  logic [11:0]                   beat_r;
  logic                          step_r;
  logic                          out_valid_r;
  sct_pkg::out_item_t            out_r;
  logic                          div_start;
  logic [sct_pkg::DIV_W-1:0]     div_dividend;
  logic [sct_pkg::DVSR_W-1:0]    div_divisor;
  logic                          div_done;
  logic [sct_pkg::DIV_W-1:0]     div_q;
  logic [13:0]                   cad;
  logic                          in_range;
  logic                          load;

  sct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cad = (div_q > sct_pkg::DIV_W'(sct_pkg::CAD_MAX_Q4)) ? sct_pkg::CAD_MAX_Q4 : div_q[13:0];

  assign in_range = avg_r != 14'd0 && avg_r >= {cfg.min_beat_cadence, 4'd0}
                    && avg_r <= {cfg.max_beat_cadence, 4'd0};

  assign q_pop = state_r == B_IDLE && !q_empty;
  assign load  = state_r == B_OUT && (!out_valid_r || out_pop);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = sct_pkg::CAD_NUM;
    div_divisor  = q_data.dt;
    case (state_r)
      B_IDLE: begin
        div_start = !q_empty && q_data.cad_needed;
      end
      B_AVGS: begin
        div_start    = 1'b1;
        div_dividend = sct_pkg::DIV_W'(sum_r);
        div_divisor  = sct_pkg::DVSR_W'(fill_r);
      end
      B_BEAT: begin
        div_start   = in_range;
        div_divisor = sct_pkg::DVSR_W'(avg_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.cad_needed ? B_CAD : B_BEAT;
        end
      end
      B_CAD: begin
        if (div_done) begin
          state_nxt = B_AVGS;
        end
      end
      B_AVGS: begin
        state_nxt = B_AVG;
      end
      B_AVG: begin
        if (div_done) begin
          state_nxt = B_BEAT;
        end
      end
      B_BEAT: begin
        state_nxt = in_range ? B_BWAIT : B_OUT;
      end
      B_BWAIT: begin
        if (div_done) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (load) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load || (out_valid_r && !out_pop);
      if (state_r == B_CAD && div_done) begin
        ring_r[head_r] <= cad;
        sum_r <= sum_r - sct_pkg::SUM_W'(ring_r[head_r]) + sct_pkg::SUM_W'(cad);
        head_r <= (head_r == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_r + 1'b1;
        if (fill_r < FILL_W'(HISTORY_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (state_r == B_AVG && div_done) begin
        avg_r <= div_q[13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      step_r <= q_data.step;
    end
    if (state_r == B_BEAT && !in_range) begin
      beat_r <= 12'd0;
    end
    if (state_r == B_BWAIT && div_done) begin
      beat_r <= (div_q > sct_pkg::DIV_W'(sct_pkg::BEAT_MAX_MS)) ? sct_pkg::BEAT_MAX_MS
                                                              : div_q[11:0];
    end
    if (load) begin
      out_r.step             <= step_r;
      out_r.avg_cadence_q4   <= avg_r;
      out_r.cadence_count    <= 2'(fill_r);
      out_r.beat_interval_ms <= beat_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("Cadence history fill count exceeds the history depth.");
  a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    avg_r <= sct_pkg::CAD_MAX_Q4)
    else $error("Average cadence exceeds the cadence ceiling.");
`endif

endmodule

// ===== src/step_cadence_tracker_top.sv =====
// Front stage takes one item at a time and posts a step event to a two-entry queue, stalling
// while the queue is full. Back stage runs no division with no new cadence and the beat off,
// one with the beat on, and up to three when a new cadence is formed, all on one shared divider.
// Neither stage takes a new item before it is through with the last one.
// Reset is synchronous and active low; it clears all tracking state, empties the queue and
// the output register, and restores the register defaults with no clearing pass.
module step_cadence_tracker_top #(
  parameter int HISTORY_DEPTH = sct_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  sct_pkg::in_item_t                 in_data,
  output logic                              out_empty,
  input  logic                              out_pop,
  output sct_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sct_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  sct_pkg::cfg_t     cfg_r;
  sct_pkg::step_ev_t fq_wdata;
  sct_pkg::step_ev_t fq_rdata;
  logic              fq_push;
  logic              fq_full;
  logic              fq_pop;
  logic              fq_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magnitude_threshold <= 12'd250;
      cfg_r.refractory_ms       <= 16'd300;
      cfg_r.min_interval_ms     <= 16'd100;
      cfg_r.min_beat_cadence    <= 10'd20;
      cfg_r.max_beat_cadence    <= 10'd300;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sct_pkg::REG_MAG_THR:    cfg_r.magnitude_threshold <= cfg_wdata[11:0];
        sct_pkg::REG_REFRACTORY: cfg_r.refractory_ms       <= cfg_wdata;
        sct_pkg::REG_MIN_INTVL:  cfg_r.min_interval_ms     <= cfg_wdata;
        sct_pkg::REG_MIN_BEAT:   cfg_r.min_beat_cadence    <= cfg_wdata[9:0];
        sct_pkg::REG_MAX_BEAT:   cfg_r.max_beat_cadence    <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  sct_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_data  (fq_wdata)
  );

  sct_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  sct_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (fq_empty),
    .q_data    (fq_rdata),
    .q_pop     (fq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
